// File: design/hng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hng_pkg;

  localparam int HNG_MAX_COUNT   = 2048;
  localparam int HNG_VALUE_WIDTH = 64;
  localparam int HNG_INDEX_W     = 12;

  localparam logic [2:0] HNG_MUL_TWO   = 3'd2;
  localparam logic [2:0] HNG_MUL_THREE = 3'd3;
  localparam logic [2:0] HNG_MUL_FIVE  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD3,
    ST_RD5,
    ST_STEP,
    ST_OUT
  } hng_state_t;

  typedef enum logic [1:0] {
    RD_TWO,
    RD_THREE,
    RD_FIVE,
    RD_RESULT
  } hng_rd_sel_t;

  typedef struct packed {
    logic        req_ready;
    logic        load_req;
    logic        rd_en;
    hng_rd_sel_t rd_sel;
    logic        seed;
    logic        cap_a;
    logic        cap_b;
    logic        step;
    logic        load_out;
  } hng_cmd_t;

  typedef struct packed {
    logic req_beat;
    logic req_zero;
    logic fill_ge_n;
    logic fill_zero;
    logic out_free;
  } hng_status_t;

endpackage

`default_nettype wire

// File: design/hng_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hng_req_if;
  logic        valid;
  logic        ready;
  logic [11:0] index_wanted;

  modport source (output valid, output index_wanted, input ready);
  modport sink   (input valid, input index_wanted, output ready);
  modport mon    (input valid, input index_wanted, input ready);
endinterface

interface hng_rsp_if #(
  parameter int VALUE_WIDTH = 64
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] smooth_value;

  modport source (output valid, output smooth_value, input ready);
  modport sink   (input valid, input smooth_value, output ready);
  modport mon    (input valid, input smooth_value, input ready);
endinterface

`default_nettype wire

// File: design/hamming_number_generator.sv
// Channel   Direction  Payload                  Beat taken when
// in_ch     sink       index_wanted [11:0]      valid && ready
// out_ch    source     smooth_value [VW-1:0]    valid && ready
//
// A request adds table entries one by one until the table covers its index;
// the first entry after reset is seeded with one, and each later entry reads
// its three source entries in turn through the single read port of the table.
// Covered requests read the table directly; an index of zero answers zero.
// Reset is synchronous and active low; it empties the table logically.
// A waiting result does not block the next request beat, but the next result
// is held back until out_ch takes the previous one.
`timescale 1ns / 1ps
`default_nettype none

module hamming_number_generator #(
  parameter int MAX_COUNT   = hng_pkg::HNG_MAX_COUNT,
  parameter int VALUE_WIDTH = hng_pkg::HNG_VALUE_WIDTH
) (
  input  wire       clk,
  input  wire       rst_n,
  hng_req_if.sink   in_ch,
  hng_rsp_if.source out_ch
);
  import hng_pkg::*;

  hng_cmd_t    cmd;
  hng_status_t status;

  hng_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  hng_dp #(
    .MAX_COUNT   (MAX_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule

`default_nettype wire

// File: design/hng_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hng_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  hng_pkg::hng_status_t status,
  output hng_pkg::hng_cmd_t    cmd
);
  import hng_pkg::*;

  hng_state_t state_r;
  hng_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (status.req_beat) begin
          state_nxt = status.req_zero ? ST_OUT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.fill_ge_n) begin
          state_nxt = ST_OUT;
        end else if (!status.fill_zero) begin
          state_nxt = ST_RD3;
        end
      end
      ST_RD3:  state_nxt = ST_RD5;
      ST_RD5:  state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_CHECK;
      ST_OUT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_TWO;
    case (state_r)
      ST_IDLE: begin
        cmd.req_ready = 1'b1;
        cmd.load_req  = status.req_beat;
      end
      ST_CHECK: begin
        if (status.fill_ge_n) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RESULT;
        end else if (status.fill_zero) begin
          cmd.seed = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TWO;
        end
      end
      ST_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_THREE;
        cmd.cap_a  = 1'b1;
      end
      ST_RD5: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FIVE;
        cmd.cap_b  = 1'b1;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
      end
      ST_OUT: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/hng_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hng_dp #(
  parameter int MAX_COUNT   = hng_pkg::HNG_MAX_COUNT,
  parameter int VALUE_WIDTH = hng_pkg::HNG_VALUE_WIDTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  hng_req_if.sink              in_ch,
  hng_rsp_if.source            out_ch,
  input  hng_pkg::hng_cmd_t    cmd,
  output hng_pkg::hng_status_t status
);
  import hng_pkg::*;

  localparam int PTR_W  = $clog2(MAX_COUNT);
  localparam int FILL_W = $clog2(MAX_COUNT + 1);

  function automatic logic [VALUE_WIDTH-1:0] sat_mul(
    input logic [VALUE_WIDTH-1:0] v,
    input logic [2:0]             k
  );
    logic [VALUE_WIDTH+2:0] p;
    begin
      p = {3'b000, v} * {{VALUE_WIDTH{1'b0}}, k};
      if (p[VALUE_WIDTH+2:VALUE_WIDTH] != 3'b000) begin
        sat_mul = '1;
      end else begin
        sat_mul = p[VALUE_WIDTH-1:0];
      end
    end
  endfunction

  logic [VALUE_WIDTH-1:0] mem [MAX_COUNT];

  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      n_r;
  logic                   zero_r;
  logic [PTR_W-1:0]       ptr_two_r;
  logic [PTR_W-1:0]       ptr_three_r;
  logic [PTR_W-1:0]       ptr_five_r;
  logic [VALUE_WIDTH-1:0] rdata_r;
  logic [VALUE_WIDTH-1:0] prod_a_r;
  logic [VALUE_WIDTH-1:0] prod_b_r;
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_value_r;

  logic [31:0]            index_ext;
  logic [FILL_W-1:0]      n_nxt;
  logic [FILL_W-1:0]      n_minus_one;
  logic [PTR_W-1:0]       rd_addr;
  logic [PTR_W-1:0]       wr_addr;
  logic                   wr_en;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] prod_c;
  logic [VALUE_WIDTH-1:0] min_ab;
  logic [VALUE_WIDTH-1:0] min_all;

  assign index_ext   = 32'(in_ch.index_wanted);
  assign n_nxt       = (index_ext > 32'(MAX_COUNT)) ? FILL_W'(MAX_COUNT)
                                                    : FILL_W'(in_ch.index_wanted);
  assign n_minus_one = n_r - FILL_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_TWO:    rd_addr = ptr_two_r;
      RD_THREE:  rd_addr = ptr_three_r;
      RD_FIVE:   rd_addr = ptr_five_r;
      RD_RESULT: rd_addr = n_minus_one[PTR_W-1:0];
      default:   rd_addr = ptr_two_r;
    endcase
  end

  assign prod_c  = sat_mul(rdata_r, HNG_MUL_FIVE);
  assign min_ab  = (prod_a_r < prod_b_r) ? prod_a_r : prod_b_r;
  assign min_all = (prod_c < min_ab) ? prod_c : min_ab;

  assign wr_en   = cmd.seed | cmd.step;
  assign wr_addr = fill_r[PTR_W-1:0];
  assign wr_data = cmd.seed ? VALUE_WIDTH'(1) : min_all;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      n_r    <= n_nxt;
      zero_r <= (in_ch.index_wanted == '0);
    end
    if (cmd.cap_a) begin
      prod_a_r <= sat_mul(rdata_r, HNG_MUL_TWO);
    end
    if (cmd.cap_b) begin
      prod_b_r <= sat_mul(rdata_r, HNG_MUL_THREE);
    end
    if (cmd.load_out) begin
      out_value_r <= zero_r ? '0 : rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      ptr_two_r   <= '0;
      ptr_three_r <= '0;
      ptr_five_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.step) begin
        if (prod_a_r == min_all) begin
          ptr_two_r <= ptr_two_r + PTR_W'(1);
        end
        if (prod_b_r == min_all) begin
          ptr_three_r <= ptr_three_r + PTR_W'(1);
        end
        if (prod_c == min_all) begin
          ptr_five_r <= ptr_five_r + PTR_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = cmd.req_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.smooth_value = out_value_r;

  assign status.req_beat  = in_ch.valid & cmd.req_ready;
  assign status.req_zero  = (in_ch.index_wanted == '0);
  assign status.fill_ge_n = (fill_r >= n_r);
  assign status.fill_zero = (fill_r == '0);
  assign status.out_free  = ~out_valid_r | out_ch.ready;

endmodule

`default_nettype wire

// File: design/hng_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hng_checker #(
  parameter int VALUE_WIDTH = hng_pkg::HNG_VALUE_WIDTH
) (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire [hng_pkg::HNG_INDEX_W-1:0]    in_index_wanted,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [VALUE_WIDTH-1:0]             out_smooth_value
);

  logic in_beat;
  logic out_free;

  assign in_beat  = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // A result that is offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_smooth_value))
    else $error("stalled result changed");

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("second request taken while one is in flight");

  // An index of zero answers with zero when the output is free.
  a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_index_wanted == '0) && out_free
      |-> ##2 (out_valid && (out_smooth_value == '0)))
    else $error("index zero did not return zero");

endmodule

bind hamming_number_generator hng_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_hng_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_index_wanted  (in_ch.index_wanted),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_smooth_value (out_ch.smooth_value)
);

`default_nettype wire

// File: bench/tb_hamming_number_generator.sv
`timescale 1ns / 1ps

module tb_hamming_number_generator;

  import hng_pkg::*;

  localparam int VW          = HNG_VALUE_WIDTH;
  localparam int MAX_N       = HNG_MAX_COUNT;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 40000;
  localparam int TAIL_CYCLES = 16;

  typedef logic [VW-1:0] smooth_t;
  typedef logic [HNG_INDEX_W-1:0] index_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hng_req_if in_if ();
  hng_rsp_if #(.VALUE_WIDTH(VW)) out_if ();

  hamming_number_generator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #1 clk = ~clk;

  smooth_t     smooth_list [0:MAX_N-1];
  int unsigned list_filled = 0;
  int unsigned at_two = 0;
  int unsigned at_three = 0;
  int unsigned at_five = 0;

  smooth_t     pending_values [$];
  smooth_t     oldest_value;
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;

  function automatic smooth_t times_sat(smooth_t v, int unsigned k);
    smooth_t lim;
    lim = '1;
    if (v > lim / k) return lim;
    return v * k;
  endfunction

  function automatic smooth_t list_entry(int unsigned idx);
    if (idx >= list_filled || idx >= MAX_N) return '0;
    return smooth_list[idx];
  endfunction

  function automatic void grow_list();
    smooth_t by_two, by_three, by_five, least;
    if (list_filled >= MAX_N) return;
    if (list_filled == 0) begin
      smooth_list[0] = smooth_t'(1);
      list_filled = 1;
      return;
    end
    by_two   = times_sat(list_entry(at_two), 2);
    by_three = times_sat(list_entry(at_three), 3);
    by_five  = times_sat(list_entry(at_five), 5);
    least = (by_two < by_three) ? by_two : by_three;
    if (by_five < least) least = by_five;
    smooth_list[list_filled] = least;
    list_filled++;
    if (by_two == least) at_two++;
    if (by_three == least) at_three++;
    if (by_five == least) at_five++;
  endfunction

  function automatic smooth_t nth_smooth(index_t idx);
    int unsigned n;
    n = 32'(idx);
    if (n == 0) return '0;
    if (n > MAX_N) n = MAX_N;
    while (list_filled < n) grow_list();
    return list_entry(n - 1);
  endfunction

  function automatic index_t pick_index(bit wide);
    int unsigned roll, top;
    roll = $urandom_range(99);
    top = list_filled;
    if (roll < 10) return '0;
    if (wide && roll < 40) return index_t'($urandom_range(4095));
    if (roll < 40 && top > 0) return index_t'($urandom_range(top, 1));
    top = top + $urandom_range(40, 1);
    if (top > 4095) top = 4095;
    return index_t'(top);
  endfunction

  // Valid stays high after a beat, so back-to-back beats need no idle gap.
  task automatic send_index(index_t idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.index_wanted <= idx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_values.push_back(nth_smooth(idx));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_small_indices();
    index_t picks [16] = '{12'd1, 12'd0, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd7,
                           12'd8, 12'd9, 12'd10, 12'd11, 12'd12, 12'd13, 12'd6,
                           12'd0};
    foreach (picks[i]) send_index(picks[i]);
  endtask

  task automatic test_random_growth(int unsigned count);
    repeat (count) send_index(pick_index(1'b0));
  endtask

  task automatic test_receiver_holdoff();
    int unsigned saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_seq++;
    repeat (10) send_index(pick_index(1'b0));
    send_idle_pct = saved_pct;
  endtask

  task automatic test_extreme_indices();
    index_t picks [9] = '{12'd2047, 12'd2048, 12'd2049, 12'hFFF, 12'hAAA,
                          12'h555, 12'h800, 12'd1, 12'd0};
    foreach (picks[i]) send_index(picks[i]);
  endtask

  task automatic test_random_wide(int unsigned count);
    repeat (count) send_index(pick_index(1'b1));
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_values.size() == 0) begin
        $error("smooth_value: unexpected beat, actual %0d", out_if.smooth_value);
        err_count++;
      end else begin
        oldest_value = pending_values.pop_front();
        if (out_if.smooth_value !== oldest_value) begin
          $error("smooth_value: expected %0d actual %0d", oldest_value,
                 out_if.smooth_value);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("hamming_number_generator: mismatch");
      $finish;
    end
  end

  initial begin
    in_if.valid        <= 1'b0;
    in_if.index_wanted <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 65;
    test_small_indices();
    test_random_growth(40);

    send_idle_pct = 65;
    recv_idle_pct = 22;
    test_receiver_holdoff();
    test_random_growth(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    test_extreme_indices();
    test_random_wide(30);

    wait_drained();
    if (err_count == 0 && pending_values.size() == 0) begin
      $display("hamming_number_generator: match");
    end else begin
      $display("hamming_number_generator: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
design/hng_pkg.sv
design/hng_if.sv
design/hng_ctrl.sv
design/hng_dp.sv
design/hamming_number_generator.sv
design/hng_checker.sv
bench/tb_hamming_number_generator.sv
